[design/cccm_pkg.sv]
`default_nettype none

package cccm_pkg;

  localparam int unsigned ROW_BITS_W       = 64;
  localparam int unsigned COUNT_W          = 16;
  localparam int unsigned ROW_WIDTH_W      = 7;
  localparam int unsigned MAX_ROW_BITS_DEF = 64;
  localparam int unsigned TABLE_DEPTH_DEF  = 64;

  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = 7'd64;
  localparam logic [COUNT_W-1:0]     COUNT_MAX     = 16'hFFFF;

  typedef struct packed {
    logic [ROW_BITS_W-1:0] row_bits;
    logic                  start_new;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] max_count;
    logic               table_overflow;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan_en;
    logic update;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;
    logic miss;
  } status_t;

endpackage

`default_nettype wire

[design/cccm_ram.sv]
`default_nettype none

module cccm_ram #(
  parameter int unsigned WIDTH = 80,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[design/cccm_ctrl.sv]
`default_nettype none

module cccm_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output cccm_pkg::cmd_t        cmd_o,
  input  wire cccm_pkg::status_t sts_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  always_comb begin
    cmd_o.load    = (state_q == S_IDLE) && in_valid_i;
    cmd_o.scan_en = (state_q == S_SCAN);
    cmd_o.update  = (state_q == S_UPDATE) && (!out_valid_q || out_ready_i);
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_o.update || (out_valid_q && !out_ready_i);
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (sts_i.hit || sts_i.miss) begin
            state_q <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          // The result waits here until the output register is free.
          if (!out_valid_q || out_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(sts_i.hit && sts_i.miss))
    else $error("hit and miss reported together");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd_o.update))
    else $error("result shown without a table update");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_SCAN) && !in_ready_o)
    else $error("accepted item did not start a scan");

endmodule

`default_nettype wire

[design/cccm_dp.sv]
`default_nettype none

module cccm_dp #(
  parameter int unsigned MAX_ROW_BITS = cccm_pkg::MAX_ROW_BITS_DEF,
  parameter int unsigned TABLE_DEPTH  = cccm_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [cccm_pkg::ROW_WIDTH_W-1:0]    cfg_wdata_i,
  input  wire cccm_pkg::in_item_t                  in_data_i,
  output cccm_pkg::out_item_t                      out_data_o,
  input  wire cccm_pkg::cmd_t                      cmd_i,
  output cccm_pkg::status_t                        sts_o
);

  localparam int unsigned AW    = $clog2(TABLE_DEPTH);
  localparam int unsigned CW    = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CNTW  = cccm_pkg::COUNT_W;
  localparam int unsigned WORDW = MAX_ROW_BITS + CNTW;

  logic [cccm_pkg::ROW_WIDTH_W-1:0] row_width_q;
  logic [cccm_pkg::ROW_WIDTH_W-1:0] eff_width;
  logic [MAX_ROW_BITS-1:0]          width_mask;
  logic [MAX_ROW_BITS-1:0]          row_masked;
  logic [MAX_ROW_BITS-1:0]          key_d;
  logic [MAX_ROW_BITS-1:0]          key_q;

  logic [CW-1:0]   used_q;
  logic [CNTW-1:0] best_q;
  logic            ovf_q;
  logic [CW-1:0]   idx_q;
  logic            cmp_vld_q;
  logic [AW-1:0]   cmp_idx_q;
  logic            found_q;
  logic [AW-1:0]   upd_idx_q;
  logic [CNTW-1:0] upd_cnt_q;
  cccm_pkg::out_item_t out_q;

  logic            issue;
  logic            hit;
  logic            miss;
  logic            full;
  logic            do_write;
  logic [CNTW-1:0] new_cnt;
  logic [CNTW-1:0] best_d;
  logic            ovf_d;
  logic [WORDW-1:0] rdata;
  logic [MAX_ROW_BITS-1:0] rd_key;
  logic [CNTW-1:0]  rd_cnt;

  // A width of zero counts as one column; anything above the maximum is clipped.
  always_comb begin
    if (row_width_q == '0) begin
      eff_width = cccm_pkg::ROW_WIDTH_W'(1);
    end else if (row_width_q > cccm_pkg::ROW_WIDTH_W'(MAX_ROW_BITS)) begin
      eff_width = cccm_pkg::ROW_WIDTH_W'(MAX_ROW_BITS);
    end else begin
      eff_width = row_width_q;
    end
    for (int i = 0; i < MAX_ROW_BITS; i++) begin
      width_mask[i] = (cccm_pkg::ROW_WIDTH_W'(i) < eff_width);
    end
    row_masked = in_data_i.row_bits[MAX_ROW_BITS-1:0] & width_mask;
    // A row and its complement share the key whose bit 0 is clear.
    key_d = row_masked[0] ? (~row_masked & width_mask) : row_masked;
  end

  assign rd_key = rdata[WORDW-1:CNTW];
  assign rd_cnt = rdata[CNTW-1:0];

  // Reads go out one entry per cycle; each compare sees the entry read the cycle before.
  assign hit   = cmd_i.scan_en && cmp_vld_q && (rd_key == key_q);
  assign issue = cmd_i.scan_en && !hit && (idx_q < used_q);
  assign miss  = cmd_i.scan_en && !cmp_vld_q && !(idx_q < used_q);
  assign full  = (used_q == CW'(TABLE_DEPTH));

  assign sts_o.hit  = hit;
  assign sts_o.miss = miss;

  assign do_write = cmd_i.update && (found_q || !full);
  assign new_cnt  = found_q ? upd_cnt_q : CNTW'(1);

  always_comb begin
    best_d = best_q;
    ovf_d  = ovf_q;
    if (do_write && (new_cnt > best_q)) begin
      best_d = new_cnt;
    end
    if (cmd_i.update && !found_q && full) begin
      ovf_d = 1'b1;
    end
  end

  cccm_ram #(
    .WIDTH(WORDW),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (do_write),
    .waddr_i(upd_idx_q),
    .wdata_i({key_q, new_cnt}),
    .re_i   (issue),
    .raddr_i(idx_q[AW-1:0]),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= cccm_pkg::ROW_WIDTH_RST;
      used_q      <= '0;
      best_q      <= '0;
      ovf_q       <= 1'b0;
      idx_q       <= '0;
      cmp_vld_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        row_width_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        idx_q     <= '0;
        cmp_vld_q <= 1'b0;
        if (in_data_i.start_new) begin
          used_q <= '0;
          best_q <= '0;
          ovf_q  <= 1'b0;
        end
      end else if (cmd_i.scan_en) begin
        cmp_vld_q <= issue;
        if (issue) begin
          idx_q <= idx_q + CW'(1);
        end
      end
      if (cmd_i.update) begin
        best_q <= best_d;
        ovf_q  <= ovf_d;
        if (!found_q && !full) begin
          used_q <= used_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= key_d;
    end
    if (issue) begin
      cmp_idx_q <= idx_q[AW-1:0];
    end
    if (hit) begin
      found_q   <= 1'b1;
      upd_idx_q <= cmp_idx_q;
      upd_cnt_q <= (rd_cnt == cccm_pkg::COUNT_MAX) ? rd_cnt : rd_cnt + CNTW'(1);
    end else if (miss) begin
      found_q   <= 1'b0;
      upd_idx_q <= used_q[AW-1:0];
      upd_cnt_q <= CNTW'(1);
    end
    if (cmd_i.update) begin
      out_q.max_count      <= best_d;
      out_q.table_overflow <= ovf_d;
    end
  end

  assign out_data_o = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) used_q <= CW'(TABLE_DEPTH))
    else $error("table fill count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |=> (best_q != '0))
    else $error("maximum count zero after a row was counted");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> !cmd_i.update && !cmd_i.load)
    else $error("table read outside of a scan");

endmodule

`default_nettype wire

[design/complement_class_mode_counter.sv]
// Flow: an item is taken in the idle state, the table is scanned for its key, and then the
// table and results are updated; a miss scans every used entry, a hit stops at its entry.
// A new item is taken only after the update for the last one; the table is scanned one
// entry per cycle through one read port.
// Reset: the table is empty, the maximum count and overflow flag are zero and row_width
// is 64. The table memory needs no clearing pass; a fill count tracks it.
`default_nettype none

module complement_class_mode_counter #(
  parameter int unsigned MAX_ROW_BITS = cccm_pkg::MAX_ROW_BITS_DEF,
  parameter int unsigned TABLE_DEPTH  = cccm_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [cccm_pkg::ROW_WIDTH_W-1:0] cfg_wdata_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire cccm_pkg::in_item_t               in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output cccm_pkg::out_item_t                   out_data_o
);

  cccm_pkg::cmd_t    cmd;
  cccm_pkg::status_t sts;

  cccm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  cccm_dp #(
    .MAX_ROW_BITS(MAX_ROW_BITS),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule

`default_nettype wire

[test/tb_top.sv]
module tb_top;

  localparam int unsigned QUIET_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [cccm_pkg::ROW_WIDTH_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  cccm_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  cccm_pkg::out_item_t out_data;

  cccm_pkg::in_item_t rows_pending[$];
  cccm_pkg::out_item_t counts_expected[$];

  // Predictor state: the class table and the running results.
  logic [cccm_pkg::ROW_BITS_W-1:0] class_keys[cccm_pkg::TABLE_DEPTH_DEF];
  logic [cccm_pkg::COUNT_W-1:0] class_counts[cccm_pkg::TABLE_DEPTH_DEF];
  int unsigned classes_used = 0;
  logic [cccm_pkg::COUNT_W-1:0] best_seen = '0;
  logic dropped_any = 1'b0;
  logic [cccm_pkg::ROW_WIDTH_W-1:0] width_cfg = cccm_pkg::ROW_WIDTH_RST;

  bit in_took = 1'b0;
  bit steady = 1'b0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  complement_class_mode_counter i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always #6 clk = ~clk;

  function automatic cccm_pkg::out_item_t count_row_class(cccm_pkg::in_item_t it);
    int unsigned w;
    logic [cccm_pkg::ROW_BITS_W-1:0] mask;
    logic [cccm_pkg::ROW_BITS_W-1:0] row;
    logic [cccm_pkg::ROW_BITS_W-1:0] key;
    logic [cccm_pkg::COUNT_W-1:0] cnt;
    bit found;
    cccm_pkg::out_item_t res;
    w = int'(width_cfg);
    if (w == 0) w = 1;
    if (w > cccm_pkg::MAX_ROW_BITS_DEF) w = cccm_pkg::MAX_ROW_BITS_DEF;
    mask = (w >= cccm_pkg::ROW_BITS_W) ? '1 : ((64'd1 << w) - 64'd1);
    row = it.row_bits & mask;
    if (it.start_new) begin
      classes_used = 0;
      best_seen = '0;
      dropped_any = 1'b0;
    end
    // A row and its complement share the key whose bit 0 is clear.
    key = row[0] ? (~row & mask) : row;
    found = 1'b0;
    cnt = '0;
    for (int i = 0; i < classes_used && !found; i++) begin
      if (class_keys[i] == key) begin
        if (class_counts[i] != cccm_pkg::COUNT_MAX) class_counts[i] = class_counts[i] + 1'b1;
        cnt = class_counts[i];
        found = 1'b1;
      end
    end
    if (!found) begin
      if (classes_used < cccm_pkg::TABLE_DEPTH_DEF) begin
        class_keys[classes_used] = key;
        class_counts[classes_used] = cccm_pkg::COUNT_W'(1);
        classes_used++;
        cnt = cccm_pkg::COUNT_W'(1);
      end else begin
        dropped_any = 1'b1;
      end
    end
    if (cnt > best_seen) best_seen = cnt;
    res.max_count = best_seen;
    res.table_overflow = dropped_any;
    return res;
  endfunction

  // Driver: new items and ready change only at the falling edge.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_took) begin
        in_took = 1'b0;
        if (rows_pending.size() != 0 && (steady || $urandom_range(99) >= 24)) begin
          in_valid <= 1'b1;
          in_data <= rows_pending.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= steady || ($urandom_range(99) >= 24);
    end
  end

  // Monitor: handshakes and register writes are sampled at the rising edge.
  always @(posedge clk) begin : monitor
    cccm_pkg::out_item_t want;
    if (rst_n) begin
      if (cfg_we) width_cfg = cfg_wdata;
      if (in_valid && in_ready) begin
        counts_expected.insert(counts_expected.size(), count_row_class(in_data));
        in_took = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (counts_expected.size() == 0) begin
          $display("%0t: unexpected item, max_count %0d table_overflow %0d", $time,
                   out_data.max_count, out_data.table_overflow);
          mismatches++;
        end else begin
          want = counts_expected.pop_front();
          if (out_data.max_count !== want.max_count) begin
            $display("%0t: max_count expected %0d, got %0d", $time, want.max_count,
                     out_data.max_count);
            mismatches++;
          end
          if (out_data.table_overflow !== want.table_overflow) begin
            $display("%0t: table_overflow expected %0d, got %0d", $time,
                     want.table_overflow, out_data.table_overflow);
            mismatches++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL complement_class_mode_counter");
        $finish;
      end
    end
  end

  task automatic add_row(input logic [cccm_pkg::ROW_BITS_W-1:0] bits, input logic fresh);
    cccm_pkg::in_item_t it;
    it.row_bits = bits;
    it.start_new = fresh;
    rows_pending.insert(rows_pending.size(), it);
  endtask

  // Waits until the block has returned every result it owes.
  task automatic settle();
    while (rows_pending.size() != 0 || in_valid || counts_expected.size() != 0)
      @(negedge clk);
  endtask

  task automatic set_width(input logic [cccm_pkg::ROW_WIDTH_W-1:0] w);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= w;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // One matrix: every class appears once first, then random picks from the
  // classes, each either as is or complemented, with some noise rows.
  task automatic add_matrix(input int unsigned n_rows, input int unsigned n_classes,
                            input logic fresh);
    logic [cccm_pkg::ROW_BITS_W-1:0] pool[$];
    logic [cccm_pkg::ROW_BITS_W-1:0] bits;
    for (int i = 0; i < n_classes; i++) begin
      bits = {$urandom, $urandom};
      pool.insert(pool.size(), bits);
    end
    for (int j = 0; j < n_rows; j++) begin
      if (j < n_classes) bits = pool[j];
      else if ($urandom_range(9) == 0) bits = {$urandom, $urandom};
      else bits = pool[$urandom_range(n_classes - 1)];
      if ($urandom_range(1)) bits = ~bits;
      add_row(bits, (j == 0) ? fresh : ($urandom_range(49) == 0));
    end
  endtask

  initial begin : stimulus
    int unsigned random_rows;
    int unsigned phase;
    int unsigned n_mats;
    int unsigned n_rows;
    int unsigned n_classes;
    logic [cccm_pkg::ROW_WIDTH_W-1:0] w;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed rows at the reset width of 64.
    add_row(64'h0000_0000_0000_0000, 1'b1);
    add_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    add_row(64'h8000_0000_0000_0000, 1'b0);
    add_row(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    add_row(64'h0000_0000_0000_0001, 1'b0);
    add_row(64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
    add_row(64'hFFFF_FFFF_FFFF_FFFE, 1'b1);
    settle();
    // A width of zero counts as one column; the table is kept across the change.
    set_width(7'd0);
    add_row(64'hDEAD_BEEF_0123_4567, 1'b0);
    add_row(64'h0000_0000_0000_0001, 1'b0);
    add_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    settle();
    // A width above the row size counts as the full row.
    set_width(7'd127);
    add_row(64'h0000_0000_0000_0001, 1'b0);
    add_row(64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
    settle();
    // Bits above a narrow width are ignored.
    set_width(7'd4);
    add_row(64'hFFFF_FFFF_FFFF_FFF0, 1'b1);
    add_row(64'h0000_0000_0000_000F, 1'b0);
    add_row(64'hA5A5_A5A5_A5A5_A5A5, 1'b0);
    add_row(64'h5A5A_5A5A_5A5A_5A5A, 1'b0);
    settle();
    set_width(7'd1);
    add_row(64'h0000_0000_0000_0000, 1'b1);
    add_row(64'h0000_0000_0000_0001, 1'b0);
    settle();
    set_width(7'd64);
    // Fill the table past its depth so that rows are dropped.
    add_matrix(90, 70, 1'b1);
    settle();

    random_rows = 0;
    phase = 0;
    while (random_rows < 900) begin
      case ($urandom_range(11))
        0: w = 7'd0;
        1: w = 7'd1;
        2: w = 7'd2;
        3: w = 7'd5;
        4: w = 7'd8;
        5: w = 7'd31;
        6: w = 7'd63;
        7: w = 7'd64;
        8: w = 7'd65;
        9: w = 7'd127;
        default: w = cccm_pkg::ROW_WIDTH_W'($urandom_range(127));
      endcase
      set_width(w);
      steady = (phase == 1);
      n_mats = $urandom_range(3, 1);
      for (int m = 0; m < n_mats; m++) begin
        if ($urandom_range(7) == 0) begin
          n_classes = 70;
          n_rows = 90;
        end else begin
          n_classes = $urandom_range(6, 1);
          n_rows = $urandom_range(60, 10);
        end
        add_matrix(n_rows, n_classes, (m != 0) || ($urandom_range(9) < 7));
        random_rows += n_rows;
      end
      settle();
      phase++;
    end
    steady = 1'b0;

    repeat (cccm_pkg::TABLE_DEPTH_DEF + 4) @(negedge clk);
    if (mismatches == 0 && counts_expected.size() == 0) begin
      $display("PASS complement_class_mode_counter");
    end else begin
      $display("FAIL complement_class_mode_counter");
    end
    $finish;
  end

endmodule
